// ----- hw/rtl/bf3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 box filter package
// Shared widths, constants and types of the 3x3 mean filter on a pixel stream.
// ----------------------------------------------------------------------------
package bf3_pkg;

   localparam int PIXEL_W            = 8;
   localparam int SUM_W              = 12;   // nine 8-bit pixels
   localparam int FRAME_WIDTH_W      = 10;
   localparam int FRAME_HEIGHT_W     = 12;
   localparam int CSR_DATA_W         = 12;
   localparam int MIN_SIZE           = 5;
   localparam int RESET_FRAME_WIDTH  = 400;
   localparam int RESET_FRAME_HEIGHT = 400;
   localparam int DEF_MAX_WIDTH      = 512;
   localparam int DEF_MAX_HEIGHT     = 4095;

   // floor(sum / 9) == (sum * 7282) >> 16 for every sum below 2^SUM_W.
   localparam int DIV9_MULT_W = 13;
   localparam logic [DIV9_MULT_W-1:0] DIV9_MULT = 13'd7282;
   localparam int DIV9_SHIFT  = 16;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } bf3_csr_type;

   // Per-item control decided when the item enters.
   typedef struct packed {
      logic emit;
      logic interior;
      logic frame_end;
   } bf3_tag_type;

   // What the window stage hands to the mean stage.
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [PIXEL_W-1:0] centre;
      logic               interior;
      logic               frame_end;
   } bf3_sum_type;

endpackage

// ----- hw/rtl/box_filter_3x3_stream_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 box filter on a grayscale pixel stream
// Replaces inner pixels of a raster frame by the truncated mean of their 3x3
// neighborhood and passes the two outer rows and columns through.
// ----------------------------------------------------------------------------
// Usage: pixels of a frame enter on the req_ channel in raster order with
// req_tuser low; each result item on the rsp_ channel is the pixel one row and
// one column behind, so the first frame_width+1 pixels give no result. Once the
// whole frame has arrived, items with req_tuser high flush the frame_width+1
// pending results; rsp_tlast marks the last result of the frame, after which a
// new frame starts. Pixels sent after a full frame and flush items sent before
// it is full are dropped. frame_width and frame_height are written on the csr_
// port between frames and are clamped to 5..MAX_WIDTH and 5..MAX_HEIGHT.
// Throughput is one item per cycle; each item does one read and one write of
// the dual-row line store, a RAM whose read is issued as the item is accepted.
// A result passes the line read, the window sum and the divide by nine, each
// registered, before it leaves the output register. When rsp_tready is
// low, items keep entering until the window and mean stages are full, then
// req_tready drops. Reset clears position, counters and the window; the line
// store needs no clearing pass and the size returns to 400 by 400.
// ----------------------------------------------------------------------------
module box_filter_3x3_stream_top #(
   parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bf3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bf3_pkg::PIXEL_W-1:0]    req_tdata,   // [7:0] pixel
   input  logic                           req_tuser,   // [0] mode (1 = flush)
   // result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bf3_pkg::PIXEL_W-1:0]    rsp_tdata,   // [7:0] out_pixel
   output logic                           rsp_tlast,   // frame_end
   // configuration
   input  logic                           csr_we,
   input  bf3_pkg::bf3_csr_type           csr_index,
   input  logic [bf3_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WV_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

   localparam int RST_W = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;
   localparam int RST_H = (RESET_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT :
                          RESET_FRAME_HEIGHT;
   localparam int RST_TOTAL = RST_W * RST_H;

   // Clamped frame size and pixel count, kept ready for the control logic.
   logic [WV_W-1:0]           width_ff, width_in, width_clamp;
   logic [ROW_W-1:0]          height_ff, height_in, height_clamp;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [FRAME_WIDTH_W-1:0]  wr_width;
   logic [FRAME_HEIGHT_W-1:0] wr_height;

   always_comb begin
      wr_width  = csr_wdata[FRAME_WIDTH_W-1:0];
      wr_height = csr_wdata[FRAME_HEIGHT_W-1:0];

      if (int'(wr_width) < MIN_SIZE) begin
         width_clamp = WV_W'(MIN_SIZE);
      end else if (int'(wr_width) > MAX_WIDTH) begin
         width_clamp = WV_W'(MAX_WIDTH);
      end else begin
         width_clamp = WV_W'(wr_width);
      end

      if (int'(wr_height) < MIN_SIZE) begin
         height_clamp = ROW_W'(MIN_SIZE);
      end else if (int'(wr_height) > MAX_HEIGHT) begin
         height_clamp = ROW_W'(MAX_HEIGHT);
      end else begin
         height_clamp = ROW_W'(wr_height);
      end

      width_in  = width_ff;
      height_in = height_ff;
      total_in  = total_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               width_in = width_clamp;
               total_in = CNT_W'(width_clamp) * CNT_W'(height_ff);
            end
            CSR_FRAME_HEIGHT: begin
               height_in = height_clamp;
               total_in  = CNT_W'(width_ff) * CNT_W'(height_clamp);
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WV_W'(RST_W);
         height_ff <= ROW_W'(RST_H);
         total_ff  <= CNT_W'(RST_TOTAL);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         total_ff  <= total_in;
      end
   end

   // Position tracking and item classification.
   logic                 req_accept;
   logic                 go_valid;
   logic [COL_W-1:0]     go_addr;
   logic [PIXEL_W-1:0]   go_pixel;
   bf3_tag_type          go_tag;

   assign req_accept = req_tvalid && req_tready;

   bf3_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .frame_w     (width_ff),
      .frame_h     (height_ff),
      .frame_total (total_ff),
      .accept      (req_accept),
      .mode        (req_tuser),
      .pixel       (req_tdata),
      .go_valid    (go_valid),
      .go_addr     (go_addr),
      .go_pixel    (go_pixel),
      .go_tag      (go_tag)
   );

   // Line store: one entry per column, holding the two rows above
   // (older row in the upper byte).
   logic                 wr_en;
   logic [COL_W-1:0]     wr_addr;
   logic [2*PIXEL_W-1:0] wr_data;
   logic [2*PIXEL_W-1:0] rd_data;

   bf3_ram #(
      .WIDTH (2 * PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (go_valid),
      .rd_addr (go_addr),
      .rd_data (rd_data)
   );

   // Window columns and nine-pixel sum.
   logic        win_valid;
   bf3_sum_type win_info;
   logic        mean_free;

   bf3_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (go_valid),
      .in_addr   (go_addr),
      .in_pixel  (go_pixel),
      .in_tag    (go_tag),
      .free      (req_tready),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .out_valid (win_valid),
      .out_info  (win_info),
      .down_free (mean_free)
   );

   // Divide by nine and output register.
   bf3_mean u_mean (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .in_info    (win_info),
      .free       (mean_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hw/rtl/bf3_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bf3_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 box filter position control
// Tracks row, column and output count of the frame and classifies each item.
// ----------------------------------------------------------------------------
module bf3_ctrl #(
   parameter int MAX_WIDTH  = bf3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bf3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]                frame_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]               frame_h,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]     frame_total,
   input  logic                                          accept,
   input  logic                                          mode,
   input  logic [bf3_pkg::PIXEL_W-1:0]                   pixel,
   output logic                                          go_valid,
   output logic [$clog2(MAX_WIDTH)-1:0]                  go_addr,
   output logic [bf3_pkg::PIXEL_W-1:0]                   go_pixel,
   output bf3_pkg::bf3_tag_type                          go_tag
);
   import bf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WV_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int CW    = WV_W + 1;
   localparam int RW    = ROW_W + 1;

   logic [COL_W-1:0] col_ff, col_in, col1, col2;
   logic [ROW_W-1:0] row_ff, row_in, row1, row2;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt1;
   logic             full_ff, full_in, full1, full2;
   logic             ignore, pix_mode, wrap0, wrap1, emit, interior, last;
   logic [CW-1:0]    col2x;

   always_comb begin
      pix_mode = (mode == MODE_PIXEL);
      ignore   = pix_mode ? full_ff : !full_ff;

      // A column left at or past the width wraps before the item is placed.
      wrap0 = CW'(col_ff) >= CW'(frame_w);
      col1  = wrap0 ? '0 : col_ff;
      row1  = (wrap0 && !full_ff) ? row_ff + ROW_W'(1) : row_ff;
      full1 = full_ff || (wrap0 && (row1 >= frame_h));

      if (pix_mode) begin
         emit     = (row1 >= ROW_W'(2)) || ((row1 == ROW_W'(1)) && (col1 != '0));
         interior = (row1 >= ROW_W'(3)) && ((RW'(row1) + RW'(2)) <= RW'(frame_h)) &&
                    (col1 >= COL_W'(3)) && ((CW'(col1) + CW'(2)) <= CW'(frame_w));
      end else begin
         emit     = 1'b1;
         interior = 1'b0;
      end

      col2x = CW'(col1) + CW'(1);
      wrap1 = col2x >= CW'(frame_w);
      col2  = wrap1 ? '0 : col2x[COL_W-1:0];
      row2  = (wrap1 && !full1) ? row1 + ROW_W'(1) : row1;
      full2 = full1 || (wrap1 && (row2 >= frame_h));

      cnt1 = cnt_ff + CNT_W'(1);
      last = emit && (cnt1 >= frame_total);

      go_valid = accept && !ignore;
      go_addr  = col1;
      go_pixel = pix_mode ? pixel : '0;
      go_tag   = '{emit: emit, interior: interior, frame_end: last};

      col_in  = col_ff;
      row_in  = row_ff;
      cnt_in  = cnt_ff;
      full_in = full_ff;
      if (go_valid) begin
         if (last) begin
            col_in  = '0;
            row_in  = '0;
            cnt_in  = '0;
            full_in = 1'b0;
         end else begin
            col_in  = col2;
            row_in  = row2;
            full_in = full2;
            cnt_in  = emit ? cnt1 : cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         cnt_ff  <= '0;
         full_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         cnt_ff  <= cnt_in;
         full_ff <= full_in;
      end
   end

endmodule

// ----- hw/rtl/bf3_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 box filter window stage
// Takes the two stored rows for the item's column, updates the line store and
// the window columns, and forms the nine-pixel sum.
// ----------------------------------------------------------------------------
module bf3_window #(
   parameter int MAX_WIDTH = bf3_pkg::DEF_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [$clog2(MAX_WIDTH)-1:0]      in_addr,
   input  logic [bf3_pkg::PIXEL_W-1:0]       in_pixel,
   input  bf3_pkg::bf3_tag_type              in_tag,
   output logic                              free,
   input  logic [2*bf3_pkg::PIXEL_W-1:0]     rd_data,
   output logic                              wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
   output logic [2*bf3_pkg::PIXEL_W-1:0]     wr_data,
   output logic                              out_valid,
   output bf3_pkg::bf3_sum_type              out_info,
   input  logic                              down_free
);
   import bf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                   s1_v_ff, s1_v_in;
   logic [COL_W-1:0]       s1_addr_ff;
   logic [PIXEL_W-1:0]     s1_px_ff;
   bf3_tag_type            s1_tag_ff;
   logic                   fwd_ff, fwd_in;
   logic [2*PIXEL_W-1:0]   fwd_data_ff;
   logic [PIXEL_W-1:0]     win_ff [6];
   logic [2*PIXEL_W-1:0]   line;
   logic [PIXEL_W-1:0]     top, mid;
   logic                   adv;

   always_comb begin
      adv  = s1_v_ff && (down_free || !s1_tag_ff.emit);
      free = !s1_v_ff || adv;

      // The previous item writes this column at the edge the next one reads it.
      line = fwd_ff ? fwd_data_ff : rd_data;
      top  = line[2*PIXEL_W-1:PIXEL_W];
      mid  = line[PIXEL_W-1:0];

      wr_en   = adv;
      wr_addr = s1_addr_ff;
      wr_data = {mid, s1_px_ff};

      s1_v_in = free ? in_valid : s1_v_ff;
      fwd_in  = in_valid && adv && (in_addr == s1_addr_ff);

      out_valid          = s1_v_ff && s1_tag_ff.emit;
      out_info.sum       = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_px_ff) +
                           SUM_W'(win_ff[0]) + SUM_W'(win_ff[1]) + SUM_W'(win_ff[2]) +
                           SUM_W'(win_ff[3]) + SUM_W'(win_ff[4]) + SUM_W'(win_ff[5]);
      out_info.centre    = win_ff[4];
      out_info.interior  = s1_tag_ff.interior;
      out_info.frame_end = s1_tag_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s1_v_ff <= s1_v_in;
         if (adv) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top;
            win_ff[4] <= mid;
            win_ff[5] <= s1_px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && free) begin
         s1_addr_ff  <= in_addr;
         s1_px_ff    <= in_pixel;
         s1_tag_ff   <= in_tag;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/bf3_mean.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// 3x3 box filter mean stage
// Divides an inner pixel's window sum by nine through a reciprocal multiply,
// else passes the centre pixel; holds the result item in the output register.
// ----------------------------------------------------------------------------
module bf3_mean (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  bf3_pkg::bf3_sum_type        in_info,
   output logic                        free,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [bf3_pkg::PIXEL_W-1:0] rsp_tdata,
   output logic                        rsp_tlast
);
   import bf3_pkg::*;

   localparam int PROD_W = SUM_W + DIV9_MULT_W;

   logic               s2_v_ff;
   bf3_sum_type        s2_info_ff;
   logic               out_v_ff;
   logic [PIXEL_W-1:0] out_px_ff, out_px_in;
   logic               out_last_ff;
   logic               out_free;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      out_free  = !out_v_ff || rsp_tready;
      free      = !s2_v_ff || out_free;
      prod      = PROD_W'(s2_info_ff.sum) * PROD_W'(DIV9_MULT);
      out_px_in = s2_info_ff.interior ? prod[DIV9_SHIFT +: PIXEL_W] : s2_info_ff.centre;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (free) begin
            s2_v_ff <= in_valid;
         end
         if (out_free) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && free) begin
         s2_info_ff <= in_info;
      end
      if (s2_v_ff && out_free) begin
         out_px_ff   <= out_px_in;
         out_last_ff <= s2_info_ff.frame_end;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_px_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- dv/box_filter_3x3_stream_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench of the 3x3 box filter stream
// Sends whole frames of several sizes through the filter, with stray pixels
// and early flush items mixed in. A scoreboard class keeps its own copy of the
// line store, window and frame position, predicts every output pixel, and
// checks the result items in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module box_filter_3x3_stream_top_tb;
   import bf3_pkg::*;

   localparam int IDLE_MAX          = 18;
   localparam int STALL_LIMIT       = 1000;  // cycles with no item moving
   localparam int SETTLE_CYCLES     = 16;
   localparam int SMALL_FRAME_ITEMS = 1100;

   // Idling styles for either side.
   localparam int PACE_NONE   = 0;
   localparam int PACE_SPARSE = 1;
   localparam int PACE_HEAVY  = 2;

   // Frame content styles.
   localparam int FILL_CHECKER  = 0;
   localparam int FILL_RANDOM   = 1;
   localparam int FILL_WHITE    = 2;
   localparam int FILL_EXTREMES = 3;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_end;
   } mean_pixel_t;

   // The block clamps both sizes to MIN_SIZE..limit.
   function automatic int unsigned size_in_use(int unsigned value, int unsigned limit);
      if (value < MIN_SIZE) return MIN_SIZE;
      if (value > limit) return limit;
      return value;
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the filter and holds the output pixels still owed.
   // -------------------------------------------------------------------------
   class box_mean_scoreboard;
      bit [PIXEL_W-1:0]        row_store [2*DEF_MAX_WIDTH];
      bit [PIXEL_W-1:0]        window [6];
      int unsigned             row_pos;
      int unsigned             col_pos;
      int unsigned             out_count;
      bit                      frame_full;
      bit [FRAME_WIDTH_W-1:0]  width_reg;
      bit [FRAME_HEIGHT_W-1:0] height_reg;
      mean_pixel_t             pending_pixels [$];
      int unsigned             errors;

      function new();
         row_pos    = 0;
         col_pos    = 0;
         out_count  = 0;
         frame_full = 1'b0;
         width_reg  = FRAME_WIDTH_W'(RESET_FRAME_WIDTH);
         height_reg = FRAME_HEIGHT_W'(RESET_FRAME_HEIGHT);
         errors     = 0;
      endfunction

      function void set_register(bf3_csr_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_FRAME_WIDTH:  width_reg  = value[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: height_reg = value[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      endfunction

      // A column at or past the row end wraps; rows stop counting once full.
      function void wrap_column(int unsigned cols, int unsigned rows);
         if (col_pos >= cols) begin
            col_pos = 0;
            if (!frame_full) begin
               row_pos++;
               if (row_pos >= rows) frame_full = 1'b1;
            end
         end
      endfunction

      function void accept_item(logic mode, logic [PIXEL_W-1:0] pixel);
         int unsigned        cols;
         int unsigned        rows;
         logic [PIXEL_W-1:0] src;
         logic [PIXEL_W-1:0] top;
         logic [PIXEL_W-1:0] mid;
         logic [PIXEL_W-1:0] centre;
         int unsigned        sum;
         bit                 emit;
         bit                 interior;
         mean_pixel_t        owed;
         cols = size_in_use(32'(width_reg), DEF_MAX_WIDTH);
         rows = size_in_use(32'(height_reg), DEF_MAX_HEIGHT);
         // Stray pixels after a full frame and early flushes are dropped.
         if (mode == MODE_PIXEL && frame_full) return;
         if (mode == MODE_DRAIN && !frame_full) return;
         src = (mode == MODE_DRAIN) ? '0 : pixel;
         wrap_column(cols, rows);
         if (mode == MODE_PIXEL) begin
            emit     = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
            interior = row_pos >= 3 && row_pos + 2 <= rows &&
                       col_pos >= 3 && col_pos + 2 <= cols;
         end else begin
            emit     = 1'b1;
            interior = 1'b0;
         end
         top    = row_store[DEF_MAX_WIDTH + col_pos];
         mid    = row_store[col_pos];
         centre = window[4];
         sum    = 32'(top) + 32'(mid) + 32'(src);
         for (int k = 0; k < 6; k++) sum += 32'(window[k]);
         for (int k = 0; k < 3; k++) window[k] = window[k + 3];
         window[3] = top;
         window[4] = mid;
         window[5] = src;
         row_store[DEF_MAX_WIDTH + col_pos] = mid;
         row_store[col_pos]                 = src;
         col_pos++;
         wrap_column(cols, rows);
         if (!emit) return;
         // Nine pixels of at most 255 never average above 255.
         owed.pixel = interior ? PIXEL_W'(sum / 9) : centre;
         out_count++;
         owed.frame_end = (out_count >= cols * rows);
         if (owed.frame_end) begin
            row_pos    = 0;
            col_pos    = 0;
            out_count  = 0;
            frame_full = 1'b0;
         end
         pending_pixels.push_back(owed);
      endfunction

      task flag_mismatch(string what);
         errors++;
         $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_result(logic [PIXEL_W-1:0] pixel, logic frame_end);
         mean_pixel_t owed;
         if (pending_pixels.size() == 0) begin
            flag_mismatch($sformatf("output pixel %0d with none expected", pixel));
            return;
         end
         owed = pending_pixels.pop_front();
         if (pixel !== owed.pixel)
            flag_mismatch($sformatf("out_pixel %0d, expected %0d", pixel, owed.pixel));
         if (frame_end !== owed.frame_end)
            flag_mismatch($sformatf("frame_end %0b, expected %0b", frame_end,
                                    owed.frame_end));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block and its signals.
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [PIXEL_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we;
   bf3_csr_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   box_mean_scoreboard sb;
   int                 req_pace;
   int                 rsp_pace;
   int unsigned        small_items;
   int unsigned        quiet_cycles;

   box_filter_3x3_stream_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Number of cycles a side waits before its next item.
   function automatic int draw_gap(int pace);
      case (pace)
         PACE_NONE:   return 0;
         PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, IDLE_MAX) : 0;
         default:     return $urandom_range(0, IDLE_MAX);
      endcase
   endfunction

   // A frame size, now and then below the minimum.
   function automatic logic [CSR_DATA_W-1:0] draw_size(int unsigned hi);
      return CSR_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4)
                                                     : $urandom_range(5, hi));
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel(int fill, int unsigned n,
                                                     int unsigned cols);
      case (fill)
         FILL_CHECKER:  return (((n / cols) + (n % cols)) % 2 == 1) ? 8'hFF : 8'h00;
         FILL_WHITE:    return 8'hFF;
         FILL_EXTREMES: begin
            case ($urandom_range(0, 2))
               0:       return 8'h00;
               1:       return 8'hFF;
               default: return PIXEL_W'($urandom_range(0, 255));
            endcase
         end
         default:       return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Inputs change at the falling edge; a handshake is judged at the rising
   // edge. tvalid stays high after an item, so the next call either replaces
   // the item at once or lowers tvalid for its gap.
   task automatic send_item(logic mode, logic [PIXEL_W-1:0] pixel);
      int gap;
      gap = draw_gap(req_pace);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.accept_item(mode, pixel);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Sizes are only written with the block idle: every owed pixel has come
   // back, and dropped items have had time to leave the pipeline.
   task automatic set_size(logic [CSR_DATA_W-1:0] width_value,
                           logic [CSR_DATA_W-1:0] height_value);
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= width_value;
      @(posedge clock);
      sb.set_register(CSR_FRAME_WIDTH, width_value);
      @(negedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= height_value;
      @(posedge clock);
      sb.set_register(CSR_FRAME_HEIGHT, height_value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One frame: all pixels, then the flush items. With noise on, a flush
   // item lands just before the last pixel and a pixel just after the frame
   // is full, and more of both are sprinkled at random; all are dropped.
   task automatic run_frame(logic [CSR_DATA_W-1:0] width_value,
                            logic [CSR_DATA_W-1:0] height_value,
                            int fill, bit noisy);
      int unsigned cols;
      int unsigned rows;
      set_size(width_value, height_value);
      cols = size_in_use(32'(sb.width_reg), DEF_MAX_WIDTH);
      rows = size_in_use(32'(sb.height_reg), DEF_MAX_HEIGHT);
      req_pace = $urandom_range(PACE_NONE, PACE_HEAVY);
      rsp_pace = $urandom_range(PACE_NONE, PACE_HEAVY);
      for (int unsigned n = 0; n < cols * rows; n++) begin
         if (noisy && (n == cols * rows - 1 || $urandom_range(0, 15) == 0))
            send_item(MODE_DRAIN, PIXEL_W'($urandom_range(0, 255)));
         send_item(MODE_PIXEL, pick_pixel(fill, n, cols));
      end
      for (int unsigned n = 0; n <= cols; n++) begin
         if (noisy && (n == 0 || $urandom_range(0, 7) == 0))
            send_item(MODE_PIXEL, PIXEL_W'($urandom_range(0, 255)));
         send_item(MODE_DRAIN, PIXEL_W'($urandom_range(0, 255)));
      end
      end_burst();
      small_items += cols * rows + cols + 1;
   endtask

   // Result side: accepts with random stalls and hands each item to the
   // scoreboard.
   initial begin : result_sink
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = draw_gap(rsp_pace);
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // Watchdog: a long stretch with no item moving on either side is a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("box_filter_3x3_stream_top_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      sb           = new();
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = MODE_PIXEL;
      rsp_tready   = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_FRAME_WIDTH;
      csr_wdata    = '0;
      req_pace     = PACE_NONE;
      rsp_pace     = PACE_NONE;
      small_items  = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: both sizes below the minimum clamp to 5 by 5. A checkerboard
      // of black and white puts the extremes on every pixel and gives the one
      // inner pixel a true mean; a flush before the frame is full and a pixel
      // after it are both dropped.
      run_frame(0, 3, FILL_CHECKER, 1'b1);

      // Random small frames, sizes now and then below the minimum.
      while (small_items < SMALL_FRAME_ITEMS) begin
         run_frame(draw_size(12), draw_size(10),
                   $urandom_range(FILL_CHECKER, FILL_EXTREMES), 1'($urandom_range(0, 1)));
      end

      // Wait for the owed pixels, then a little longer for anything unexpected.
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("box_filter_3x3_stream_top_tb passed");
      end else begin
         $display("box_filter_3x3_stream_top_tb failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/bf3_pkg.sv
hw/rtl/bf3_ram.sv
hw/rtl/bf3_ctrl.sv
hw/rtl/bf3_window.sv
hw/rtl/bf3_mean.sv
hw/rtl/box_filter_3x3_stream_top.sv
dv/box_filter_3x3_stream_top_tb.sv
